### rtl/core/glos_pkg.sv
// Shared types and constants for the grid line-of-sight block.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps

package glos_pkg;

   // Width of one grid coordinate as it arrives on the request channel
   localparam int COORD_W   = 8;
   localparam int DIV_CNT_W = $clog2(COORD_W);

   // Request action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Reply kind codes
   localparam logic REPLY_ACK    = 1'b0;
   localparam logic REPLY_ANSWER = 1'b1;

   typedef logic [COORD_W-1:0] coord_type;

   // Walk axis: primary stepping direction
   typedef enum logic {
      AXIS_X,
      AXIS_Y
   } glos_axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_WALK,
      ST_DRAIN,
      ST_REPLY
   } glos_state_type;

   // Controller to datapath
   typedef struct packed {
      logic          load;
      logic          write;
      logic          div_start;
      logic          walk_init;
      logic          walk_step;
      glos_axis_type axis;
      logic          rsp_load;
   } glos_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic walk_end;
      logic rsp_free;
   } glos_status_type;

endpackage

### rtl/core/glos_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module glos_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write, or read into the output register
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/glos_div.sv
// Restoring divider, one quotient bit per cycle, for coordinate deltas.
// Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  glos_pkg::coord_type num,
   input  glos_pkg::coord_type den,
   output glos_pkg::coord_type quo,
   output glos_pkg::coord_type rem,
   output logic               done
);
   import glos_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   coord_type            quo_ff, quo_in;
   coord_type            rem_ff, rem_in;
   coord_type            den_ff, den_in;
   logic [COORD_W:0]     trial;
   logic                 fits;

   // One restoring step: shift in the next dividend bit and try to subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[COORD_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[COORD_W-2:0], fits};
         rem_in = fits ? COORD_W'(trial - {1'b0, den_ff}) : trial[COORD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(COORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

### rtl/core/glos_datapath.sv
// Datapath: request capture, exact rational cell walk, map RAM and reply register.
// Depends on glos_pkg, glos_ram and glos_div.
`timescale 1ns / 1ps

module glos_datapath #(
   parameter int GRID_SIZE = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  glos_pkg::glos_cmd_type    cmd,
   output glos_pkg::glos_status_type status,
   input  logic                      req_action,
   input  glos_pkg::coord_type       req_start_x,
   input  glos_pkg::coord_type       req_start_y,
   input  glos_pkg::coord_type       req_end_x,
   input  glos_pkg::coord_type       req_end_y,
   input  logic                      req_blocked,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_reply_kind,
   output logic                      rsp_path_clear
);
   import glos_pkg::*;

   localparam int DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(DEPTH);

   // Captured request
   logic      act_ff;
   coord_type x0_ff, y0_ff, x1_ff, y1_ff;
   logic      blk_ff;

   // Walk state
   coord_type i_ff, i_in;
   coord_type q_ff, q_in;
   coord_type r_ff, r_in;
   coord_type qs_ff, qs_in;
   coord_type rs_ff, rs_in;

   // Read pipeline and result
   logic rd_pend_ff, oob_pend_ff;
   logic blocked_ff, blocked_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_clear_ff;

   // Derived walk geometry
   coord_type        ax, ay;
   logic             sx_neg, sy_neg;
   coord_type        prim0, sec0, num, den;
   logic             prim_neg, sec_neg;
   logic [COORD_W:0] r_sum;
   logic             wrap;
   coord_type        sec_off, prim, sec;
   coord_type        cur_x, cur_y, cell_x, cell_y;
   logic             in_grid;
   logic [AW-1:0]    cell_addr;
   logic             ram_we;
   logic             ram_rdata;
   coord_type        div_quo, div_rem;
   logic             div_done;

   // Deltas and the axis mapping of the active walk
   always_comb begin
      sx_neg = (x1_ff < x0_ff);
      sy_neg = (y1_ff < y0_ff);
      ax     = sx_neg ? (x0_ff - x1_ff) : (x1_ff - x0_ff);
      ay     = sy_neg ? (y0_ff - y1_ff) : (y1_ff - y0_ff);
      if (cmd.axis == AXIS_X) begin
         prim0    = x0_ff;
         prim_neg = sx_neg;
         sec0     = y0_ff;
         sec_neg  = sy_neg;
         num      = ay;
         den      = ax;
      end else begin
         prim0    = y0_ff;
         prim_neg = sy_neg;
         sec0     = x0_ff;
         sec_neg  = sx_neg;
         num      = ax;
         den      = ay;
      end
   end

   glos_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (den),
      .quo   (div_quo),
      .rem   (div_rem),
      .done  (div_done)
   );

   // Cell: primary steps by one, secondary by floor(num*i/den) (ceil if negative)
   always_comb begin
      prim    = prim_neg ? (prim0 - i_ff) : (prim0 + i_ff);
      sec_off = q_ff + COORD_W'(sec_neg && (r_ff != '0));
      sec     = sec_neg ? (sec0 - sec_off) : (sec0 + sec_off);
      cur_x   = (cmd.axis == AXIS_X) ? prim : sec;
      cur_y   = (cmd.axis == AXIS_X) ? sec : prim;
   end

   // Advance quotient and remainder by the precomputed step
   always_comb begin
      r_sum = {1'b0, r_ff} + {1'b0, rs_ff};
      wrap  = (r_sum >= {1'b0, den});
      i_in  = i_ff;
      q_in  = q_ff;
      r_in  = r_ff;
      qs_in = qs_ff;
      rs_in = rs_ff;
      if (cmd.walk_init) begin
         i_in  = '0;
         q_in  = '0;
         r_in  = '0;
         qs_in = div_quo;
         rs_in = div_rem;
      end else if (cmd.walk_step) begin
         i_in = i_ff + 1'b1;
         q_in = q_ff + qs_ff + COORD_W'(wrap);
         r_in = wrap ? COORD_W'(r_sum - {1'b0, den}) : r_sum[COORD_W-1:0];
      end
   end

   // Map address for the write cell or the walk cell
   always_comb begin
      cell_x    = cmd.write ? x0_ff : cur_x;
      cell_y    = cmd.write ? y0_ff : cur_y;
      in_grid   = (32'(cell_x) < 32'(GRID_SIZE)) && (32'(cell_y) < 32'(GRID_SIZE));
      cell_addr = in_grid ? AW'(32'(cell_y) * 32'(GRID_SIZE) + 32'(cell_x)) : '0;
      ram_we    = cmd.write && in_grid;
   end

   glos_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (cell_addr),
      .wdata (blk_ff),
      .rdata (ram_rdata)
   );

   // Accumulate blocked cells from the registered read; load or hold the reply
   always_comb begin
      blocked_in = blocked_ff;
      if (cmd.load) begin
         blocked_in = 1'b0;
      end else if (rd_pend_ff && (oob_pend_ff || ram_rdata)) begin
         blocked_in = 1'b1;
      end
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         blocked_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= cmd.walk_step;
         blocked_ff   <= blocked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         x0_ff  <= req_start_x;
         y0_ff  <= req_start_y;
         x1_ff  <= req_end_x;
         y1_ff  <= req_end_y;
         blk_ff <= req_blocked;
      end
      i_ff        <= i_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      qs_ff       <= qs_in;
      rs_ff       <= rs_in;
      oob_pend_ff <= !in_grid;
      if (cmd.rsp_load) begin
         rsp_kind_ff  <= (act_ff == ACT_QUERY) ? REPLY_ANSWER : REPLY_ACK;
         rsp_clear_ff <= (act_ff == ACT_QUERY) && !blocked_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.walk_end = (i_ff == den);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_kind_ff;
   assign rsp_path_clear = rsp_clear_ff;

   // Never overwrite a reply that is still held by a stall
   a_rsp_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("reply loaded over a stalled beat");

   // Remainder stays below the divisor while walking
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (r_ff < den))
      else $error("walk remainder out of range");

   // Step counter never passes the walk length
   a_step_bound : assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (i_ff < den))
      else $error("walk stepped past its end");

   // A write acknowledge never reports a clear path
   a_ack_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == REPLY_ACK)) |-> !rsp_clear_ff)
      else $error("write acknowledge carries a path answer");

endmodule

### rtl/core/glos_ctrl.sv
// Controller: sequences write, divide, two walks, drain and reply.
// Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_action,
   output logic                      req_stall,
   input  glos_pkg::glos_status_type status,
   output glos_pkg::glos_cmd_type    cmd
);
   import glos_pkg::*;

   glos_state_type state_ff, state_in;
   glos_axis_type  axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               axis_in  = AXIS_X;
               state_in = (req_action == ACT_QUERY) ? ST_DIV_START : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_REPLY;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.walk_init = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!status.walk_end) begin
               cmd.walk_step = 1'b1;
            end else if (axis_ff == AXIS_X) begin
               axis_in  = AXIS_Y;
               state_in = ST_DIV_START;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### rtl/core/grid_line_of_sight.sv
// Grid line-of-sight checker over a GRID_SIZE x GRID_SIZE obstacle bitmap.
// Top level: joins glos_ctrl and glos_datapath; depends on glos_pkg.
//
// Request channel (req_*): a beat with req_action = write sets or clears the
// cell (req_start_x, req_start_y) to req_blocked; a beat with
// req_action = query asks whether the segment from start to end is clear.
// Result channel (rsp_*): one beat per request; rsp_reply_kind tells an
// acknowledge from an answer, rsp_path_clear carries the answer.
// A query runs, for the x-stepped and then the y-stepped cell line, one divide
// of the deltas on one shared divider (a start state, a busy step per quotient
// bit and a done pulse each) and then a walk, one map bit per cycle from the
// single RAM port, plus an end step per walk; then a drain state and a reply
// state. A write passes through a write state and a reply state. One item is in work at a time.
// The reply register parts the channels: the next request is accepted as
// soon as a reply is loaded, even while rsp_stall holds it.
// Reset clears the controller and the reply valid; the map is not cleared
// and must be written before it is read.
`timescale 1ns / 1ps

module grid_line_of_sight #(
   parameter int GRID_SIZE = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  glos_pkg::coord_type req_start_x,
   input  glos_pkg::coord_type req_start_y,
   input  glos_pkg::coord_type req_end_x,
   input  glos_pkg::coord_type req_end_y,
   input  logic                req_blocked,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_reply_kind,
   output logic                rsp_path_clear
);
   import glos_pkg::*;

   glos_cmd_type    cmd;
   glos_status_type status;

   glos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   glos_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_blocked    (req_blocked),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_kind (rsp_reply_kind),
      .rsp_path_clear (rsp_path_clear)
   );

endmodule
